FILE: rtl/i2d_pkg.sv
// ----------------------------------------------------------------------------
// i2d_pkg: shared types and constants for the 64-bit decimal text converter
// Widths, character codes, the queue entry and the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package i2d_pkg;

   // payload widths
   localparam int VALUE_W = 64;
   localparam int CHAR_W  = 7;

   // decimal conversion geometry: 20 digits cover 2^64-1
   localparam int BCD_DIGITS    = 20;
   localparam int BCD_W         = 4 * BCD_DIGITS;
   localparam int BITS_PER_STEP = 4;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(CONV_STEPS);
   localparam int DIGIT_IDX_W   = $clog2(BCD_DIGITS);

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // one classified word waiting for conversion
   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } i2d_item_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_FIND,
      ST_SIGN,
      ST_EMIT
   } i2d_state_type;

endpackage

`default_nettype wire

FILE: rtl/int64_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii: 64-bit binary word to decimal ASCII characters
// Signed or unsigned word in, one character per output word, msd first.
// ----------------------------------------------------------------------------
//  channel   direction  ports                               word
//  req       in         req_value, req_is_signed            one number
//  rsp       out        rsp_char_code, rsp_last             one character
//
//  Each number passes the back end in order: it is taken from the queue, the
//  shift-and-add-3 loop runs over it at four bits a cycle, its top digit is
//  found, then its n characters (1 to 20) go out in turn, a stalled output
//  holding them back.
//  A queue lets the input take further numbers while the back end is busy.
//  Reset empties the queue and the output register; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module int64_to_decimal_ascii #(
   parameter int QueueDepth = i2d_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [i2d_pkg::VALUE_W-1:0] req_value,
   input  wire logic                        req_is_signed,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   output logic [i2d_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                             rsp_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready
);
   import i2d_pkg::*;

   i2d_item_type push_item;
   logic         push_valid;
   logic         push_ready;
   i2d_item_type pop_item;
   logic         pop_valid;
   logic         pop_ready;

   // sign and magnitude
   i2d_front u_front (
      .req_value     (req_value),
      .req_is_signed (req_is_signed),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .push_item     (push_item),
      .push_valid    (push_valid),
      .push_ready    (push_ready)
   );

   // decoupling queue
   i2d_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   // conversion and character output
   i2d_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_item      (pop_item),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready)
   );

endmodule

`default_nettype wire

FILE: rtl/i2d_front.sv
// ----------------------------------------------------------------------------
// i2d_front: input classification
// Decides the sign of the incoming word and forms its unsigned magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module i2d_front (
   input  wire logic [i2d_pkg::VALUE_W-1:0] req_value,
   input  wire logic                        req_is_signed,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   output i2d_pkg::i2d_item_type            push_item,
   output logic                             push_valid,
   input  wire logic                        push_ready
);
   import i2d_pkg::*;

   logic neg;

   // sign only counts in signed mode
   assign neg = req_is_signed & req_value[VALUE_W-1];

   // magnitude, the most negative value folds to 2^63 on its own
   assign push_item.neg = neg;
   assign push_item.mag = neg ? (~req_value + VALUE_W'(1)) : req_value;

   // handshake passes straight through to the queue
   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

`default_nettype wire

FILE: rtl/i2d_queue.sv
// ----------------------------------------------------------------------------
// i2d_queue: small word queue between front and back
// Flip-flop FIFO of classified words so either side can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module i2d_queue #(
   parameter int Depth = i2d_pkg::QUEUE_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  i2d_pkg::i2d_item_type      push_item,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   output i2d_pkg::i2d_item_type      pop_item,
   output logic                       pop_valid,
   input  wire logic                  pop_ready
);
   import i2d_pkg::*;

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   i2d_item_type entries_ff [Depth];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/i2d_back.sv
// ----------------------------------------------------------------------------
// i2d_back: binary to decimal conversion and character output
// Shift-and-add-3 over four bits a cycle, then emits a minus sign for a negative number and digits from the top.
// ----------------------------------------------------------------------------
`default_nettype none

module i2d_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  i2d_pkg::i2d_item_type            pop_item,
   input  wire logic                        pop_valid,
   output logic                             pop_ready,
   output logic [i2d_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                             rsp_last,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready
);
   import i2d_pkg::*;

   i2d_state_type          state_ff, state_in;
   logic [VALUE_W-1:0]     mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   out_free;
   logic [BCD_W-1:0]       bcd_step;
   logic [DIGIT_IDX_W-1:0] top_digit;
   logic [3:0]             cur_digit;

   // one shift-and-add-3 step: correct every digit, then shift one bit in
   function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
                                               input logic bit_in);
      logic [BCD_W-1:0] a;
      a = b;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (a[i*4 +: 4] >= 4'd5) begin
            a[i*4 +: 4] = a[i*4 +: 4] + 4'd3;
         end
      end
      return {a[BCD_W-2:0], bit_in};
   endfunction

   // four dependent steps per cycle, msb first
   always_comb begin
      bcd_step = bcd_ff;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         bcd_step = dabble(bcd_step, mag_ff[VALUE_W-1-k]);
      end
   end

   // highest nonzero digit, zero when the number is zero
   always_comb begin
      top_digit = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            top_digit = DIGIT_IDX_W'(i);
         end
      end
   end

   assign cur_digit = bcd_ff[idx_ff*4 +: 4];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (pop_valid) state_in = ST_CONV;
         ST_CONV: if (step_ff == STEP_W'(CONV_STEPS - 1)) state_in = ST_FIND;
         ST_FIND: state_in = neg_ff ? ST_SIGN : ST_EMIT;
         ST_SIGN: if (out_free) state_in = ST_EMIT;
         ST_EMIT: if (out_free && idx_ff == '0) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and output register
   always_comb begin
      pop_ready    = 1'b0;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               mag_in  = pop_item.mag;
               neg_in  = pop_item.neg;
               bcd_in  = '0;
               step_in = '0;
            end
         end
         ST_CONV: begin
            bcd_in  = bcd_step;
            mag_in  = {mag_ff[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
            step_in = step_ff + STEP_W'(1);
         end
         ST_FIND: begin
            idx_in = top_digit;
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + CHAR_W'(cur_digit);
               rsp_last_in  = (idx_ff == '0);
               idx_in       = idx_ff - DIGIT_IDX_W'(1);
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/i2d_checker.sv
// ----------------------------------------------------------------------------
// i2d_checker: port-level checks for the decimal text converter
// Watches the character stream on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module i2d_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic [i2d_pkg::CHAR_W-1:0]  rsp_char_code,
   input wire logic                        rsp_last,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready
);
   import i2d_pkg::*;

   // output is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word present after reset");

   // a stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code) && $stable(rsp_last))
      else $error("stalled output word changed");

   // only minus or a decimal digit appears
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_char_code == CHAR_MINUS
                    || (rsp_char_code >= CHAR_ZERO && rsp_char_code <= CHAR_NINE))
      else $error("character outside the decimal set");

   // the sign never ends a number
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign marked as last");

   // a sign is never directly followed by another sign
   a_no_double_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_char_code == CHAR_MINUS
      |=> !(rsp_valid && rsp_char_code == CHAR_MINUS))
      else $error("two minus signs in a row");

endmodule

bind int64_to_decimal_ascii i2d_checker u_i2d_checker (.*);

`default_nettype wire
